// ===== rtl/ovl_pkg.sv =====
package ovl_pkg;

	localparam int DATA_W = 32;
	localparam int DEFAULT_CAPACITY = 16;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 5;

	// operation codes carried on tuser
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic shift_in;   // insert: each cell takes its upper neighbour's entry, the head takes the value
		logic close_gap;  // delete: cells at or past the first hit take the lower neighbour's
	} cell_ctl_t;

endpackage

// ===== rtl/ovl_cell.sv =====
module ovl_cell
	import ovl_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int INDEX = 0,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] value,
	input  logic [CNT_W-1:0]         count,
	input  logic signed [DATA_W-1:0] prev_entry,
	input  logic signed [DATA_W-1:0] next_entry,
	input  logic                     hit_in,
	output logic                     hit_out,
	output logic signed [DATA_W-1:0] entry
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic signed [DATA_W-1:0] entry_q;
	logic                     active;
	logic                     hit;

	// compare own entry and pass the running hit flag towards the tail
	assign active  = IDX < count;
	assign hit     = active && (entry_q == value);
	assign hit_out = hit_in | hit;
	assign entry   = entry_q;

	// shift towards the tail on insert, close the gap on delete
	always_ff @(posedge clk) begin
		if (ctl.shift_in) begin
			entry_q <= (INDEX == 0) ? value : prev_entry;
		end else if (ctl.close_gap && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== rtl/ordered_value_list.sv =====
// Ordered list of signed 32-bit values held in a chain of CAPACITY cells, entry 0
// at the head. A word on s_tdata (value) with s_tuser (operation) inserts at the
// head, deletes the first matching entry or searches for it; every word gives one
// result word on m_tdata with the found flag, a status (ok, not found, full) and
// the count after the operation. One operation is taken every cycle while results are
// taken (m_tready), and its result appears on the next cycle; the clock period is set
// by the compare and the first-hit chain that runs through all cells. Entry storage has
// no reset: only entries below the held count are ever compared.
module ordered_value_list
	import ovl_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] found, [2:1] status, [7:3] entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]          count_q;
	logic                      m_tvalid_q;
	logic [7:0]                m_tdata_q;
	logic                      accept;
	logic signed [DATA_W-1:0]  value;
	logic [MODE_W-1:0]         mode;
	logic                      full;
	logic                      found;
	cell_ctl_t                 ctl;
	logic [CAPACITY:0]         hit_chain;
	logic signed [DATA_W-1:0]  entries [CAPACITY];
	logic [STATUS_W-1:0]       status;
	logic [CNT_W-1:0]          count_next;
	logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;
	assign value    = signed'(s_tdata);
	assign mode     = s_tuser;
	assign full     = count_q == CAP_CNT;
	assign found    = hit_chain[CAPACITY];
	assign hit_chain[0] = 1'b0;

	// decode the operation into cell commands
	always_comb begin
		ctl.shift_in  = accept && (mode == MODE_INSERT) && !full;
		ctl.close_gap = accept && (mode == MODE_DELETE) && found;
	end

	// chain of cells, head first
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_e;
		logic signed [DATA_W-1:0] next_e;
		if (i == 0) begin : g_head
			assign prev_e = value;
		end else begin : g_body
			assign prev_e = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = entries[i];
		end else begin : g_mid
			assign next_e = entries[i+1];
		end
		ovl_cell #(
			.CAPACITY(CAPACITY),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.value(value),
			.count(count_q),
			.prev_entry(prev_e),
			.next_entry(next_e),
			.hit_in(hit_chain[i]),
			.hit_out(hit_chain[i+1]),
			.entry(entries[i])
		);
	end

	// work out status and the count after this word
	always_comb begin
		count_next = count_q;
		unique case (mode)
			MODE_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					status = ST_OK;
					count_next = count_q + CNT_W'(1);
				end
			end
			MODE_DELETE: begin
				if (found) begin
					status = ST_OK;
					count_next = count_q - CNT_W'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			default: status = found ? ST_OK : ST_NOT_FOUND;
		endcase
		count_ext = {{COUNT_OUT_W{1'b0}}, count_next};
	end

	// hold the count and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {count_ext[COUNT_OUT_W-1:0], status, found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// count never runs past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("held count beyond capacity");

	// a full result is only shown while the list is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] == ST_FULL) |-> full)
		else $error("full status with room left");

	// not found never comes with the found flag
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] == ST_NOT_FOUND) |-> !m_tdata[0])
		else $error("not found reported with found flag");

	// a successful delete drops the count by one
	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.close_gap |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not drop the count");

	// an accepted insert into a list with room grows it by one
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_in |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

endmodule
